// ===== hdl/mpst_pkg.sv =====
// mpst_pkg: shared constants and types of the mutable prefix-sum table
// used by mpst_ctrl and mutable_prefix_sum_table_core; no dependencies
package mpst_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = 10;
   localparam int LEN_W         = 11;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   // request kinds
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // per-memory strobes from the sequencer
   typedef struct packed {
      logic we;
      logic re;
   } mem_ctl_type;

endpackage

// ===== hdl/mutable_prefix_sum_table_core.sv =====
// mutable_prefix_sum_table_core: top level of the mutable prefix-sum table
// depends on mpst_pkg, mpst_ram and mpst_ctrl
//
// keeps DEPTH signed 32-bit elements and their running prefix sums in two
// one-port-read rams. after reset a clearing pass zeroes both rams, one entry
// a cycle; req_stall stays high meanwhile, csr writes are taken as ever. a
// query (req_type 1) with a valid range reads element[lo] and prefix[lo]
// together and prefix[hi] in the next cycle through the single read port of
// the prefix ram; a range flagged as an error skips the reads, and either
// result waits as long as the result register is still full. an update
// (req_type 0) writes the element, then rebuilds prefix entries max(index,1)
// .. length-1 at one entry a cycle, paced by the element ram read port; when
// max(index,1) is at or past the length no prefix entry is rebuilt, and an
// index past the table is dropped. updates give no result beat. one request
// is in flight at a time; a finished result waits in the output register and
// does not hold up the next request
module mutable_prefix_sum_table_core #(
   parameter int DEPTH = mpst_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // length register
   input  logic                               csr_wr_en,
   input  logic [mpst_pkg::LEN_W-1:0]         csr_wr_data,
   // request beats
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [mpst_pkg::IDX_W-1:0]         req_index,
   input  logic signed [mpst_pkg::DATA_W-1:0] req_value,
   input  logic [mpst_pkg::IDX_W-1:0]         req_upper_index,
   // result beats
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mpst_pkg::DATA_W-1:0] rsp_range_sum,
   output logic                               rsp_error
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = (AW + 1 > mpst_pkg::LEN_W) ? AW + 1 : mpst_pkg::LEN_W;

   // length register, clamped to the table depth
   logic [mpst_pkg::LEN_W-1:0] array_length_ff, array_length_in;
   logic [LW-1:0]              len_ext;
   logic [LW-1:0]              eff_len;

   assign array_length_in = csr_wr_en ? csr_wr_data : array_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         array_length_ff <= mpst_pkg::LEN_RESET;
      end else begin
         array_length_ff <= array_length_in;
      end
   end

   assign len_ext = LW'(array_length_ff);
   assign eff_len = (len_ext > LW'(DEPTH)) ? LW'(DEPTH) : len_ext;

   // memory ports
   mpst_pkg::mem_ctl_type       elem_ctl;
   logic [AW-1:0]               elem_waddr;
   logic [mpst_pkg::DATA_W-1:0] elem_wdata;
   logic [AW-1:0]               elem_raddr;
   logic [mpst_pkg::DATA_W-1:0] elem_rdata;
   mpst_pkg::mem_ctl_type       pfx_ctl;
   logic [AW-1:0]               pfx_waddr;
   logic [mpst_pkg::DATA_W-1:0] pfx_wdata;
   logic [AW-1:0]               pfx_raddr;
   logic [mpst_pkg::DATA_W-1:0] pfx_rdata;

   // element store
   mpst_ram #(
      .WIDTH (mpst_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_elem_ram (
      .clock (clock),
      .we    (elem_ctl.we),
      .waddr (elem_waddr),
      .wdata (elem_wdata),
      .re    (elem_ctl.re),
      .raddr (elem_raddr),
      .rdata (elem_rdata)
   );

   // prefix store; entry 0 is only ever written by the clearing pass
   mpst_ram #(
      .WIDTH (mpst_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_pfx_ram (
      .clock (clock),
      .we    (pfx_ctl.we),
      .waddr (pfx_waddr),
      .wdata (pfx_wdata),
      .re    (pfx_ctl.re),
      .raddr (pfx_raddr),
      .rdata (pfx_rdata)
   );

   // sequencer and result register
   mpst_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .eff_len         (eff_len),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_index       (req_index),
      .req_value       (req_value),
      .req_upper_index (req_upper_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_sum   (rsp_range_sum),
      .rsp_error       (rsp_error),
      .elem_ctl        (elem_ctl),
      .elem_waddr      (elem_waddr),
      .elem_wdata      (elem_wdata),
      .elem_raddr      (elem_raddr),
      .elem_rdata      (elem_rdata),
      .pfx_ctl         (pfx_ctl),
      .pfx_waddr       (pfx_waddr),
      .pfx_wdata       (pfx_wdata),
      .pfx_raddr       (pfx_raddr),
      .pfx_rdata       (pfx_rdata)
   );

`ifndef SYNTH
   // the element ram is never read and written in the same cycle
   a_elem_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(elem_ctl.we && elem_ctl.re))
      else $error("element ram read and written together");

   // the prefix ram is never read and written in the same cycle
   a_pfx_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(pfx_ctl.we && pfx_ctl.re))
      else $error("prefix ram read and written together");

   // no request beat is taken while prefix entries are being rewritten
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !pfx_ctl.we)
      else $error("request accepted during prefix sweep");

   // a prefix write is always part of a sweep that holds off new requests
   a_sweep_stalls: assert property (@(posedge clock) disable iff (reset)
      pfx_ctl.we |-> req_stall)
      else $error("prefix write while requests are open");
`endif

endmodule

// ===== hdl/mpst_ram.sv =====
// mpst_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mpst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while re is low
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/mpst_ctrl.sv =====
// mpst_ctrl: sequencer of the prefix-sum table (clearing pass, update sweep,
// query reads) and the result register; depends on mpst_pkg
module mpst_ctrl #(
   parameter int DEPTH = mpst_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int LW = (AW + 1 > mpst_pkg::LEN_W) ? AW + 1 : mpst_pkg::LEN_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [LW-1:0]                      eff_len,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [mpst_pkg::IDX_W-1:0]         req_index,
   input  logic signed [mpst_pkg::DATA_W-1:0] req_value,
   input  logic [mpst_pkg::IDX_W-1:0]         req_upper_index,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mpst_pkg::DATA_W-1:0] rsp_range_sum,
   output logic                               rsp_error,
   // element memory
   output mpst_pkg::mem_ctl_type              elem_ctl,
   output logic [AW-1:0]                      elem_waddr,
   output logic [mpst_pkg::DATA_W-1:0]        elem_wdata,
   output logic [AW-1:0]                      elem_raddr,
   input  logic [mpst_pkg::DATA_W-1:0]        elem_rdata,
   // prefix memory
   output mpst_pkg::mem_ctl_type              pfx_ctl,
   output logic [AW-1:0]                      pfx_waddr,
   output logic [mpst_pkg::DATA_W-1:0]        pfx_wdata,
   output logic [AW-1:0]                      pfx_raddr,
   input  logic [mpst_pkg::DATA_W-1:0]        pfx_rdata
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SEED  = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_QRY_B = 3'd4;
   localparam logic [2:0] S_QRY_C = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [LW-1:0]               k_ff, k_in;
   logic [LW-1:0]               kd_ff, kd_in;
   logic [AW-1:0]               hi_ff, hi_in;
   logic [mpst_pkg::DATA_W-1:0] run_ff, run_in;
   logic [mpst_pkg::DATA_W-1:0] part_ff, part_in;
   logic                        err_ff, err_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mpst_pkg::DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                        rsp_err_ff, rsp_err_in;

   logic [LW-1:0]               pos;
   logic [LW-1:0]               hi_ext;
   logic [LW-1:0]               k0;
   logic [LW-1:0]               k0m1;
   logic                        accept;
   logic                        out_free;
   logic                        rsp_load;
   logic                        qry_err;
   logic [mpst_pkg::DATA_W-1:0] run_sum;

   assign pos      = LW'(req_index);
   assign hi_ext   = LW'(req_upper_index);
   assign k0       = (pos == '0) ? LW'(1) : pos;
   assign k0m1     = k0 - LW'(1);
   assign req_stall = (state_ff != S_IDLE);
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign qry_err  = (req_index > req_upper_index) || (hi_ext >= eff_len);
   assign run_sum  = run_ff + elem_rdata;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      k_in       = k_ff;
      kd_in      = kd_ff;
      hi_in      = hi_ff;
      run_in     = run_ff;
      part_in    = part_ff;
      err_in     = err_ff;
      rsp_load   = 1'b0;
      elem_ctl   = '0;
      pfx_ctl    = '0;
      elem_waddr = AW'(req_index);
      elem_wdata = req_value;
      elem_raddr = k_ff[AW-1:0];
      pfx_waddr  = kd_ff[AW-1:0];
      pfx_wdata  = run_sum;
      pfx_raddr  = AW'(req_index);

      case (state_ff)
         S_CLEAR: begin
            elem_ctl.we = 1'b1;
            pfx_ctl.we  = 1'b1;
            elem_waddr  = clr_ff;
            elem_wdata  = '0;
            pfx_waddr   = clr_ff;
            pfx_wdata   = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_type == mpst_pkg::REQ_UPDATE) begin
                  // out-of-range positions are dropped
                  if (pos < LW'(DEPTH)) begin
                     elem_ctl.we = 1'b1;
                     if (k0 < eff_len) begin
                        pfx_ctl.re = 1'b1;
                        pfx_raddr  = k0m1[AW-1:0];
                        k_in       = k0;
                        state_in   = S_SEED;
                     end
                  end
               end else begin
                  if (qry_err) begin
                     err_in   = 1'b1;
                     state_in = S_QRY_C;
                  end else begin
                     elem_ctl.re = 1'b1;
                     elem_raddr  = AW'(req_index);
                     pfx_ctl.re  = 1'b1;
                     hi_in       = AW'(req_upper_index);
                     err_in      = 1'b0;
                     state_in    = S_QRY_B;
                  end
               end
            end
         end
         S_SEED: begin
            // running sum starts from the entry below the first one rebuilt
            run_in      = pfx_rdata;
            elem_ctl.re = 1'b1;
            kd_in       = k_ff;
            k_in        = k_ff + LW'(1);
            state_in    = S_RUN;
         end
         S_RUN: begin
            pfx_ctl.we = 1'b1;
            run_in     = run_sum;
            if (k_ff < eff_len) begin
               elem_ctl.re = 1'b1;
               kd_in       = k_ff;
               k_in        = k_ff + LW'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         S_QRY_B: begin
            part_in    = elem_rdata - pfx_rdata;
            pfx_ctl.re = 1'b1;
            pfx_raddr  = hi_ff;
            state_in   = S_QRY_C;
         end
         S_QRY_C: begin
            // prefix read data holds here until the result register frees
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_sum_in   = rsp_load ? (err_ff ? '0 : part_ff + pfx_rdata) : rsp_sum_ff;
   assign rsp_err_in   = rsp_load ? err_ff : rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      kd_ff      <= kd_in;
      hi_ff      <= hi_in;
      run_ff     <= run_in;
      part_ff    <= part_in;
      err_ff     <= err_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_error     = rsp_err_ff;

endmodule

// ===== tb/mutable_prefix_sum_table_core_test.sv =====
// mutable_prefix_sum_table_core_test: self-checking bench for the prefix-sum table core
// holds its own mirror of both stores, a directed table and length-phased random traffic
// depends on mpst_pkg and mutable_prefix_sum_table_core
module mutable_prefix_sum_table_core_test;

   localparam int TB_DEPTH     = mpst_pkg::DEPTH_DEFAULT;
   localparam int TB_IDX_W     = mpst_pkg::IDX_W;
   localparam int TB_DATA_W    = mpst_pkg::DATA_W;
   localparam int TB_LEN_W     = mpst_pkg::LEN_W;
   localparam int RESET_CYCLES = 12;
   // an update of element zero rebuilds prefix entries 1 .. length-1, one entry a cycle
   localparam int SETTLE_CYCLES = TB_DEPTH + 16;
   // limit on the slowest run of this stimulus, clearing pass included
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_GAP     = 17;
   localparam int ANY_SMALL   = 4095;
   localparam int N_PHASES    = 12;

   typedef struct packed {
      logic                   kind;
      logic [TB_IDX_W-1:0]    lo;
      logic [TB_DATA_W-1:0]   val;
      logic [TB_IDX_W-1:0]    hi;
   } request_type;

   typedef struct packed {
      logic [TB_DATA_W-1:0]   sum;
      logic                   err;
   } range_result_type;

   typedef enum logic [1:0] {
      ROW_SET_LEN,
      ROW_UPDATE,
      ROW_QUERY
   } row_op_type;

   // a = length or lower index, b = upper index; result columns only used when fixed_result
   typedef struct packed {
      row_op_type             op;
      logic [TB_LEN_W-1:0]    a;
      logic [TB_IDX_W-1:0]    b;
      logic [TB_DATA_W-1:0]   val;
      logic                   fixed_result;
      logic [TB_DATA_W-1:0]   want_sum;
      logic                   want_err;
   } directed_row_type;

   localparam int DIR_ROWS = 28;

   localparam directed_row_type DIRECTED_PLAN [DIR_ROWS] = '{
      // fresh out of reset everything reads as zero, the value field is ignored
      '{ROW_QUERY,   11'd0,    10'd1023, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_QUERY,   11'd1023, 10'd1023, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      // reversed ranges
      '{ROW_QUERY,   11'd5,    10'd4,    32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_QUERY,   11'd1023, 10'd0,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
      // element zero, largest value: prefix entry zero stays put, full rebuild
      '{ROW_UPDATE,  11'd0,    10'd0,    32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd0,    10'd0,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
      // last element, most negative value
      '{ROW_UPDATE,  11'd1023, 10'd1023, 32'h8000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd1023, 10'd1023, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{ROW_QUERY,   11'd0,    10'd1023, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_UPDATE,  11'd1,    10'd682,  32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_UPDATE,  11'd341,  10'd341,  32'h5555_5555, 1'b0, 32'h0,         1'b0},
      '{ROW_UPDATE,  11'd682,  10'd0,    32'hAAAA_AAAA, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd341,  10'd682,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd682,  10'd341,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_QUERY,   11'd1,    10'd1023, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      // short table: element written past the length leaves the prefixes alone
      '{ROW_SET_LEN, 11'd16,   10'd0,    32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_UPDATE,  11'd20,   10'd0,    32'h0000_0007, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd3,    10'd15,   32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd3,    10'd16,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_UPDATE,  11'd4,    10'd0,    32'h0000_0003, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd0,    10'd15,   32'h0000_0000, 1'b0, 32'h0,         1'b0},
      // length beyond the table clamps; entries from 16 up are now stale
      '{ROW_SET_LEN, 11'd2047, 10'd0,    32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd0,    10'd1023, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd16,   10'd20,   32'h0000_0000, 1'b0, 32'h0,         1'b0},
      // zero length: every query is flagged
      '{ROW_SET_LEN, 11'd0,    10'd0,    32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd0,    10'd0,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_UPDATE,  11'd0,    10'd0,    32'h0000_0005, 1'b0, 32'h0,         1'b0},
      '{ROW_QUERY,   11'd1023, 10'd1023, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1}
   };

   // length plan for the random part: extremes plus a spread of short tables
   localparam int PHASE_LEN [N_PHASES] = '{
      1, 2047, 0, ANY_SMALL, 1024, ANY_SMALL, 2, ANY_SMALL, 1023, ANY_SMALL, 1200, ANY_SMALL
   };

   // clock, reset and block inputs, all known from time zero
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [TB_LEN_W-1:0]         csr_wr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_type = mpst_pkg::REQ_UPDATE;
   logic [TB_IDX_W-1:0]         req_index = '0;
   logic signed [TB_DATA_W-1:0] req_value = '0;
   logic [TB_IDX_W-1:0]         req_upper_index = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [TB_DATA_W-1:0] rsp_range_sum;
   logic                        rsp_error;

   // mirror of the block's state
   logic [TB_DATA_W-1:0] elem_mirror   [TB_DEPTH];
   logic [TB_DATA_W-1:0] prefix_mirror [TB_DEPTH];
   logic [TB_LEN_W-1:0]  length_mirror = mpst_pkg::LEN_RESET;

   // range sums still owed by the block, oldest first
   range_result_type pending_sums [$];

   int unsigned fail_count    = 0;
   int unsigned n_updates     = 0;
   int unsigned n_queries     = 0;
   int unsigned n_flagged     = 0;
   int unsigned n_len_writes  = 0;
   int unsigned n_rsp_beats   = 0;
   int unsigned n_sent        = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   bit          sender_calm   = 1'b0;
   bit          receiver_calm = 1'b0;

   mutable_prefix_sum_table_core #(
      .DEPTH(TB_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_index       (req_index),
      .req_value       (req_value),
      .req_upper_index (req_upper_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_sum   (rsp_range_sum),
      .rsp_error       (rsp_error)
   );

   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < TB_DEPTH; i++) begin
         elem_mirror[TB_IDX_W'(i)]   = '0;
         prefix_mirror[TB_IDX_W'(i)] = '0;
      end
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // length in force, clamped to the table size
   function automatic int unsigned live_length();
      int unsigned len;
      len = 32'(length_mirror);
      return (len > TB_DEPTH) ? TB_DEPTH : len;
   endfunction

   // write one element, then rebuild the prefixes from there up to the length
   function automatic void apply_update(input int unsigned pos,
                                        input logic [TB_DATA_W-1:0] val);
      int unsigned k;
      if (pos >= TB_DEPTH) return;
      elem_mirror[TB_IDX_W'(pos)] = val;
      for (k = (pos < 1) ? 1 : pos; k < live_length(); k++)
         prefix_mirror[TB_IDX_W'(k)] = prefix_mirror[TB_IDX_W'(k-1)]
                                       + elem_mirror[TB_IDX_W'(k)];
   endfunction

   // sum of elements lo..hi, or the error flag for a bad range
   function automatic range_result_type sum_of_range(input int unsigned lo,
                                                     input int unsigned hi);
      range_result_type res;
      if (lo > hi || hi >= live_length()) begin
         res.sum = '0;
         res.err = 1'b1;
      end else begin
         res.sum = prefix_mirror[TB_IDX_W'(hi)] - prefix_mirror[TB_IDX_W'(lo)]
                   + elem_mirror[TB_IDX_W'(lo)];
         res.err = 1'b0;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic int unsigned draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // values lean on the wrap points, the rest is spread
   function automatic logic [TB_DATA_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return $urandom_range(0, 200) - 100;
         default: return $urandom();
      endcase
   endfunction

   // mostly in-range updates and well-formed queries, some reversed or overlong
   function automatic request_type random_request(input int unsigned live);
      request_type rq;
      int unsigned pick;
      rq.val = draw_value();
      rq.lo  = TB_IDX_W'($urandom_range(0, TB_DEPTH - 1));
      rq.hi  = TB_IDX_W'($urandom_range(0, TB_DEPTH - 1));
      pick   = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) begin
         rq.kind = mpst_pkg::REQ_UPDATE;
         if (live != 0 && pick < 8) rq.lo = TB_IDX_W'($urandom_range(0, live - 1));
      end else begin
         rq.kind = mpst_pkg::REQ_QUERY;
         if (live != 0 && pick < 7) begin
            rq.lo = TB_IDX_W'($urandom_range(0, live - 1));
            rq.hi = TB_IDX_W'($urandom_range(32'(rq.lo), live - 1));
         end else if (pick == 7) begin
            // reversed range
            rq.hi = TB_IDX_W'($urandom_range(0, TB_DEPTH - 2));
            rq.lo = TB_IDX_W'($urandom_range(32'(rq.hi) + 1, TB_DEPTH - 1));
         end else if (pick == 8 && live < TB_DEPTH) begin
            // upper bound at or past the length
            rq.hi = TB_IDX_W'($urandom_range(live, TB_DEPTH - 1));
            rq.lo = TB_IDX_W'($urandom_range(0, 32'(rq.hi)));
         end
      end
      return rq;
   endfunction

   // drive one request beat, hold it through stalls, predict on acceptance
   task automatic send_request(input request_type rq, input bit fixed_result,
                               input range_result_type fixed_res);
      range_result_type res;
      int unsigned      gap;
      req_valid       <= 1'b1;
      req_type        <= rq.kind;
      req_index       <= rq.lo;
      req_value       <= rq.val;
      req_upper_index <= rq.hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (rq.kind == mpst_pkg::REQ_UPDATE) begin
         apply_update(32'(rq.lo), rq.val);
         n_updates++;
      end else begin
         res = fixed_result ? fixed_res : sum_of_range(32'(rq.lo), 32'(rq.hi));
         pending_sums = {pending_sums, res};
         n_queries++;
         if (res.err) n_flagged++;
      end
      // idle pattern changes every 32 beats, some stretches with no gaps at all
      if (n_sent % 32 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      n_sent++;
      gap = draw_gap(sender_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every owed range sum is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sums.size() != 0) @(posedge clock);
   endtask

   // length change only once the block is idle; an update may still be rebuilding
   task automatic write_length(input logic [TB_LEN_W-1:0] len);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      length_mirror = len;
      n_len_writes++;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      directed_row_type row;
      request_type      rq;
      range_result_type fixed_res;
      int unsigned      want_len;
      int unsigned      n_items;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset length, then short, clamped and zero lengths
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         if (row.op == ROW_SET_LEN) begin
            write_length(row.a);
         end else begin
            rq.kind       = (row.op == ROW_QUERY) ? mpst_pkg::REQ_QUERY : mpst_pkg::REQ_UPDATE;
            rq.lo         = row.a[TB_IDX_W-1:0];
            rq.hi         = row.b;
            rq.val        = row.val;
            fixed_res.sum = row.want_sum;
            fixed_res.err = row.want_err;
            send_request(rq, row.fixed_result, fixed_res);
         end
      end

      // random phases, long tables get only a few beats since updates there are slow
      for (int p = 0; p < N_PHASES; p++) begin
         want_len = PHASE_LEN[p];
         if (want_len == ANY_SMALL) want_len = $urandom_range(3, 64);
         write_length(want_len[TB_LEN_W-1:0]);
         n_items = (live_length() > 128) ? 12 : 55;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 39) == 0) drain_results();
            send_request(random_request(live_length()), 1'b0, '0);
         end
      end

      // wind down: everything back, then room for a trailing rebuild or a stray beat
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d updates and %0d queries (%0d with a bad range) over %0d lengths",
               n_updates, n_queries, n_flagged, n_len_writes);
      $display("%0d result beats compared, %0d mismatches", n_rsp_beats, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // result side: random stalls, field by field compare against the oldest sum
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      range_result_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_sums.size() == 0) begin
               $display("%0t: result beat with nothing owed, range_sum %0d error %0b",
                        $time, rsp_range_sum, rsp_error);
               fail_count++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_range_sum !== want.sum) begin
                  $display("%0t: range_sum expected %0d got %0d",
                           $time, $signed(want.sum), rsp_range_sum);
                  fail_count++;
               end
               if (rsp_error !== want.err) begin
                  $display("%0t: error expected %0b got %0b", $time, want.err, rsp_error);
                  fail_count++;
               end
            end
            if (n_rsp_beats % 32 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            n_rsp_beats++;
            // stall for a gap drawn by draw_gap before taking the next beat
            hold_left = draw_gap(receiver_calm);
            if (hold_left != 0) rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
hdl/mpst_pkg.sv
hdl/mpst_ram.sv
hdl/mpst_ctrl.sv
hdl/mutable_prefix_sum_table_core.sv
tb/mutable_prefix_sum_table_core_test.sv
